/* rtl/rfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants of the RFID reader frame parser
// Register indexes, reset values, result status codes and the frame request
// descriptor passed from the byte parser to the result emitter.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int FRAME_MAX_DEF = 64;
  localparam int EPC_MAX_DEF   = 12;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_POLL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_POLL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NO_TAG      = 3'd5;

  localparam logic [7:0] RST_HEADER      = 8'd187;
  localparam logic [7:0] RST_END         = 8'd126;
  localparam logic [7:0] RST_SINGLE_POLL = 8'd34;
  localparam logic [7:0] RST_MULTI_POLL  = 8'd39;
  localparam logic [7:0] RST_FAILURE     = 8'd255;
  localparam logic [7:0] RST_NO_TAG      = 8'd21;

  // result status codes
  localparam logic [1:0] ST_TAG     = 2'd0;
  localparam logic [1:0] ST_NO_TAG  = 2'd1;
  localparam logic [1:0] ST_CMD_ERR = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] end_byte;
    logic [7:0] single_poll_code;
    logic [7:0] multi_poll_code;
    logic [7:0] failure_code;
    logic [7:0] no_tag_error;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rssi;
  } desc_t;

endpackage

/* rtl/rfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_front: byte parser
// Hunts for the header, tracks frame position, length and checksum, keeps
// the EPC bytes and issues one request descriptor per frame that has results.
// ----------------------------------------------------------------------------
module rfp_front #(
  parameter int FRAME_MAX = rfp_pkg::FRAME_MAX_DEF,
  parameter int EPC_MAX   = rfp_pkg::EPC_MAX_DEF,
  localparam int NW       = $clog2(EPC_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rfp_pkg::cfg_t       cfg_i,
  input  logic                byte_vld_i,
  input  logic [7:0]          byte_i,
  output logic                push_o,
  output rfp_pkg::desc_t      desc_o,
  output logic [NW-1:0]       cnt_o,
  output logic [7:0]          epc_o [EPC_MAX]
);
  import rfp_pkg::*;

  localparam int POS_W = $clog2(FRAME_MAX);
  localparam int TOT_W = $clog2(FRAME_MAX + 1);
  localparam int CW    = TOT_W + 4;
  localparam int EIW   = (EPC_MAX > 1) ? $clog2(EPC_MAX) : 1;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic [7:0]       epc_r [EPC_MAX];

  logic             epc_we;
  logic [CW-1:0]    p_x, total_x, plen, n_x, epc_off;
  logic [16:0]      len_full;
  logic [7:0]       sum_add;

  assign p_x      = CW'(pos_r);
  assign total_x  = CW'(total_r);
  assign len_full = {1'b0, len_hi_r, byte_i} + 17'd7;
  assign plen     = total_x - CW'(7);
  assign n_x      = plen - CW'(5);
  assign epc_off  = p_x - CW'(8);
  assign sum_add  = sum_r + byte_i;

  always_comb begin
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    len_hi_nxt = len_hi_r;
    sum_nxt    = sum_r;
    cmd_nxt    = cmd_r;
    first_nxt  = first_r;
    chk_nxt    = chk_r;
    epc_we     = 1'b0;
    push_o     = 1'b0;
    desc_o     = '0;
    cnt_o      = NW'(1);
    if (byte_vld_i) begin
      if (p_x == '0) begin
        if (byte_i == cfg_i.header_byte) begin
          sum_nxt = '0;
          pos_nxt = POS_W'(1);
        end
      end else if (p_x == CW'(1)) begin
        sum_nxt = sum_add;
        pos_nxt = pos_r + POS_W'(1);
      end else if (p_x == CW'(2)) begin
        cmd_nxt = byte_i;
        sum_nxt = sum_add;
        pos_nxt = pos_r + POS_W'(1);
      end else if (p_x == CW'(3)) begin
        len_hi_nxt = byte_i;
        sum_nxt    = sum_add;
        pos_nxt    = pos_r + POS_W'(1);
      end else if (p_x == CW'(4)) begin
        total_nxt = TOT_W'(len_full);
        if (len_full > 17'(FRAME_MAX)) begin
          pos_nxt = '0;     // oversize frame: back to hunting
        end else begin
          sum_nxt = sum_add;
          pos_nxt = pos_r + POS_W'(1);
        end
      end else if (p_x < total_x - CW'(2)) begin
        sum_nxt = sum_add;
        if (p_x == CW'(5)) begin
          first_nxt = byte_i;
        end
        if (p_x >= CW'(8) && epc_off < CW'(EPC_MAX)) begin
          epc_we = 1'b1;
        end
        pos_nxt = pos_r + POS_W'(1);
      end else if (p_x == total_x - CW'(2)) begin
        chk_nxt = byte_i;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        pos_nxt = '0;
        if (byte_i == cfg_i.end_byte) begin
          push_o = 1'b1;
          if (chk_r != sum_r) begin
            desc_o.status = ST_INVALID;
          end else if (cmd_r == cfg_i.single_poll_code ||
                       cmd_r == cfg_i.multi_poll_code) begin
            if (plen < CW'(5) || n_x == '0 || n_x > CW'(EPC_MAX)) begin
              desc_o.status = ST_INVALID;
            end else begin
              desc_o.status = ST_TAG;
              desc_o.rssi   = first_r;
              cnt_o         = n_x[NW-1:0];
            end
          end else if (cmd_r == cfg_i.failure_code && plen != '0) begin
            desc_o.status = (first_r == cfg_i.no_tag_error) ? ST_NO_TAG : ST_CMD_ERR;
          end else begin
            push_o = 1'b0;  // other commands give nothing
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      total_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_hi_r <= len_hi_nxt;
    sum_r    <= sum_nxt;
    cmd_r    <= cmd_nxt;
    first_r  <= first_nxt;
    chk_r    <= chk_nxt;
    if (epc_we) begin
      epc_r[epc_off[EIW-1:0]] <= byte_i;
    end
  end

  assign epc_o = epc_r;

endmodule

/* rtl/rfp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_queue: request queue
// Short FIFO of frame descriptors with their EPC bytes, between parser and
// emitter.
// ----------------------------------------------------------------------------
module rfp_queue #(
  parameter int EPC_MAX   = rfp_pkg::EPC_MAX_DEF,
  localparam int NW       = $clog2(EPC_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  rfp_pkg::desc_t      desc_i,
  input  logic [NW-1:0]       cnt_i,
  input  logic [7:0]          epc_i [EPC_MAX],
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output rfp_pkg::desc_t      desc_o,
  output logic [NW-1:0]       cnt_o,
  output logic [7:0]          epc_o [EPC_MAX]
);
  import rfp_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t         desc_q [QUEUE_DEPTH];
  logic [NW-1:0] cnt_q  [QUEUE_DEPTH];
  logic [7:0]    epc_q  [QUEUE_DEPTH][EPC_MAX];

  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_i && !pop_i) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      desc_q[wr_ptr_r] <= desc_i;
      cnt_q[wr_ptr_r]  <= cnt_i;
      epc_q[wr_ptr_r]  <= epc_i;
    end
  end

  assign full_o  = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (fill_r == '0);
  assign desc_o  = desc_q[rd_ptr_r];
  assign cnt_o   = cnt_q[rd_ptr_r];
  assign epc_o   = epc_q[rd_ptr_r];

endmodule

/* rtl/rfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_back: result emitter
// Expands the request at the queue head into its run of result items, one
// per cycle while the receiver pops, through a registered output stage.
// ----------------------------------------------------------------------------
module rfp_back #(
  parameter int EPC_MAX   = rfp_pkg::EPC_MAX_DEF,
  localparam int NW       = $clog2(EPC_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty_i,
  input  rfp_pkg::desc_t      desc_i,
  input  logic [NW-1:0]       cnt_i,
  input  logic [7:0]          epc_i [EPC_MAX],
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [1:0]          status_o,
  output logic [7:0]          rssi_o,
  output logic [3:0]          epc_length_o,
  output logic [3:0]          epc_index_o,
  output logic [7:0]          epc_byte_o,
  output logic                last_o
);
  import rfp_pkg::*;

  localparam int EIW = (EPC_MAX > 1) ? $clog2(EPC_MAX) : 1;

  logic [NW-1:0] idx_r;
  logic          ov_r;
  logic [1:0]    status_r;
  logic [7:0]    rssi_r;
  logic [3:0]    len_r;
  logic [3:0]    index_r;
  logic [7:0]    byte_r;
  logic          last_r;

  logic load, last_item, is_tag;

  assign load      = !q_empty_i && (!ov_r || pop_i);
  assign last_item = (idx_r == cnt_i - NW'(1));
  assign is_tag    = (desc_i.status == ST_TAG);
  assign q_pop_o   = load && last_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= last_item ? '0 : idx_r + NW'(1);
      end else if (pop_i) begin
        ov_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= desc_i.status;
      rssi_r   <= is_tag ? desc_i.rssi : '0;
      len_r    <= is_tag ? 4'(cnt_i) : '0;
      index_r  <= is_tag ? 4'(idx_r) : '0;
      byte_r   <= is_tag ? epc_i[idx_r[EIW-1:0]] : '0;
      last_r   <= last_item;
    end
  end

  assign empty_o      = !ov_r;
  assign status_o     = status_r;
  assign rssi_o       = rssi_r;
  assign epc_length_o = len_r;
  assign epc_index_o  = index_r;
  assign epc_byte_o   = byte_r;
  assign last_o       = last_r;

endmodule

/* rtl/rfid_reader_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_reader_frame_parser: receive-side frame parser of a UHF RFID reader
// Bytes from the serial link go in on the in_ queue port (push/full), one per
// cycle at most. Results come out on the out_ queue port (empty/pop): a tag
// frame gives one item per EPC byte, other frames one item, all with last set
// on the final item of the run. cfg_ writes are registered; the user must
// make them while the block is idle, which the block itself does not enforce.
// The first result of a frame passes through the request queue and the output
// register; the rest of the run follows one item per cycle while out_pop is
// held. Throughput: one byte per cycle on the input while full is low; one
// result per cycle out of the output register while the receiver pops. A
// two-entry request queue sits between the parser and the emitter; full rises
// when two frames' results are still waiting, and it holds input until the
// emitter frees an entry, so a stalled receiver only holds back input once
// that queue has filled.
// Reset: synchronous, active low; the parser hunts for a header, the queue
// and output register are empty and the registers take their defaults.
// ----------------------------------------------------------------------------
module rfid_reader_frame_parser #(
  parameter int FRAME_MAX = rfp_pkg::FRAME_MAX_DEF,
  parameter int EPC_MAX   = rfp_pkg::EPC_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_push,
  input  logic [7:0]                    in_rx_byte,
  output logic                          in_full,
  // result channel
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_rssi,
  output logic [3:0]                    out_epc_length,
  output logic [3:0]                    out_epc_index,
  output logic [7:0]                    out_epc_byte,
  output logic                          out_last,
  // configuration
  input  logic                          cfg_we,
  input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import rfp_pkg::*;

  localparam int NW = $clog2(EPC_MAX + 1);

  cfg_t cfg_r, cfg_nxt;

  // parser -> queue
  logic          f_push;
  desc_t         f_desc;
  logic [NW-1:0] f_cnt;
  logic [7:0]    f_epc [EPC_MAX];

  // queue -> emitter
  logic          q_full, q_empty, q_pop;
  desc_t         q_desc;
  logic [NW-1:0] q_cnt;
  logic [7:0]    q_epc [EPC_MAX];

  logic in_acc;

  // configuration registers; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER:      cfg_nxt.header_byte      = cfg_wdata;
        REG_END:         cfg_nxt.end_byte         = cfg_wdata;
        REG_SINGLE_POLL: cfg_nxt.single_poll_code = cfg_wdata;
        REG_MULTI_POLL:  cfg_nxt.multi_poll_code  = cfg_wdata;
        REG_FAILURE:     cfg_nxt.failure_code     = cfg_wdata;
        REG_NO_TAG:      cfg_nxt.no_tag_error     = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte      <= RST_HEADER;
      cfg_r.end_byte         <= RST_END;
      cfg_r.single_poll_code <= RST_SINGLE_POLL;
      cfg_r.multi_poll_code  <= RST_MULTI_POLL;
      cfg_r.failure_code     <= RST_FAILURE;
      cfg_r.no_tag_error     <= RST_NO_TAG;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a byte is taken only while the request queue has room
  assign in_full = q_full;
  assign in_acc  = in_push && !q_full;

  rfp_front #(
    .FRAME_MAX (FRAME_MAX),
    .EPC_MAX   (EPC_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .byte_vld_i (in_acc),
    .byte_i     (in_rx_byte),
    .push_o     (f_push),
    .desc_o     (f_desc),
    .cnt_o      (f_cnt),
    .epc_o      (f_epc)
  );

  rfp_queue #(
    .EPC_MAX (EPC_MAX)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .desc_i  (f_desc),
    .cnt_i   (f_cnt),
    .epc_i   (f_epc),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .desc_o  (q_desc),
    .cnt_o   (q_cnt),
    .epc_o   (q_epc)
  );

  rfp_back #(
    .EPC_MAX (EPC_MAX)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty_i    (q_empty),
    .desc_i       (q_desc),
    .cnt_i        (q_cnt),
    .epc_i        (q_epc),
    .q_pop_o      (q_pop),
    .pop_i        (out_pop),
    .empty_o      (out_empty),
    .status_o     (out_status),
    .rssi_o       (out_rssi),
    .epc_length_o (out_epc_length),
    .epc_index_o  (out_epc_index),
    .epc_byte_o   (out_epc_byte),
    .last_o       (out_last)
  );

endmodule
